### rtl/i3p_pkg.sv
`default_nettype none

package i3p_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int KIND_W     = 3;
  localparam int TAG_SIZE_W = 28;
  localparam int TAG_END_W  = 29;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;
  localparam int BUF_DEPTH  = 4;
  localparam int BUF_CNT_W  = 3;

  localparam logic [LEN_W-1:0]     LEN_RESET    = 7'h7F;
  localparam logic [TAG_END_W-1:0] HDR_LEN      = 29'd10;
  localparam logic [31:0]          ID_TPE1      = 32'h5450_4531;
  localparam logic [31:0]          ID_TIT2      = 32'h5449_5432;
  localparam logic [23:0]          ID_FOOT      = 24'h33_4449;
  localparam logic [7:0]           MAGIC_0      = 8'h49;
  localparam logic [7:0]           MAGIC_1      = 8'h44;
  localparam logic [7:0]           MAGIC_2      = 8'h33;
  localparam logic [7:0]           VER_3        = 8'd3;
  localparam logic [7:0]           VER_4        = 8'd4;
  localparam logic [7:0]           ENC_LATIN    = 8'd0;
  localparam logic [7:0]           ENC_UTF16    = 8'd1;
  localparam logic [7:0]           BOM_FIRST    = 8'hFF;
  localparam logic [7:0]           BOM_SECOND   = 8'hFE;
  localparam int                   EXT_FLAG_BIT = 6;
  localparam logic [1:0]           TEXT_FRAMES  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_EXT_SIZE,
    PH_EXT_SKIP,
    PH_FR_HDR,
    PH_FR_SKIP,
    PH_TX_ENC,
    PH_TX_FIRST,
    PH_TX_SEC,
    PH_TX_REST,
    PH_TX_SKIP,
    PH_DONE
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARTIST_CHAR = 3'd0,
    KIND_TITLE_CHAR  = 3'd1,
    KIND_ARTIST_END  = 3'd2,
    KIND_TITLE_END   = 3'd3,
    KIND_TAG_DONE    = 3'd4,
    KIND_NO_TAG      = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARTIST_MAX = 2'd0,
    CFG_TITLE_MAX  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    kind_e                 kind;
    logic [BYTE_W-1:0]     char_code;
    logic [TAG_END_W-1:0]  tag_end;
    logic                  last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]  count;
  } result_set_t;

endpackage

`default_nettype wire

### rtl/i3p_if.sv
`default_nettype none

interface i3p_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface i3p_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_code;
  logic [28:0] tag_end;
  logic        last;

  modport source (output valid, output kind, output char_code, output tag_end, output last,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input tag_end, input last,
                  output ready);
endinterface

interface i3p_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/i3p_core.sv
`default_nettype none

module i3p_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [i3p_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [i3p_pkg::LEN_W-1:0]     cfg_data_i,
  input  wire logic                          acc_i,
  input  wire logic [i3p_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          sof_i,
  output i3p_pkg::result_set_t               res_o
);
  import i3p_pkg::*;

  logic [LEN_W-1:0] artist_max_q, title_max_q;

  phase_e                phase_q, phase_c, phase_d;
  logic [3:0]            bc_q, bc_c, bc_d;
  logic [TAG_SIZE_W-1:0] ts_q, ts_c, ts_d;
  logic                  v3_q, v3_d, v4_q, v4_d;
  logic                  ext_q, ext_d;
  logic                  mok_q, mok_c, mok_d;
  logic [31:0]           fh_q, fh_c, fh_d;
  logic [31:0]           br_q, br_c, br_d;
  logic [1:0]            fl_q, fl_c, fl_d;
  logic                  tgt_q, tgt_d;
  logic                  enc0_q, enc0_d, enc1_q, enc1_d;
  logic                  odd_q, odd_d;
  logic [7:0]            first_q, first_d;
  logic                  bom_q, bom_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      artist_max_q <= LEN_RESET;
      title_max_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ARTIST_MAX: artist_max_q <= cfg_data_i;
        CFG_TITLE_MAX:  title_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // start of file restarts the walk
  always_comb begin
    if (acc_i && sof_i) begin
      phase_c = PH_HDR;
      bc_c    = '0;
      ts_c    = '0;
      mok_c   = 1'b1;
      fh_c    = '0;
      br_c    = '0;
      fl_c    = TEXT_FRAMES;
    end else begin
      phase_c = phase_q;
      bc_c    = bc_q;
      ts_c    = ts_q;
      mok_c   = mok_q;
      fh_c    = fh_q;
      br_c    = br_q;
      fl_c    = fl_q;
    end
  end

  always_comb begin
    logic [31:0]          fh_new;
    logic [31:0]          t32;
    logic [31:0]          rem;
    logic [LEN_W-1:0]     limit;
    logic                 ft, kept, start_fh, fin_tag, no_tag, stop;
    logic                 char_v;
    logic [7:0]           char_val;
    logic [1:0]           fl_dec;
    logic [RES_CNT_W-1:0] cnt;

    phase_d = phase_c;
    bc_d    = bc_c;
    ts_d    = ts_c;
    mok_d   = mok_c;
    fh_d    = fh_c;
    br_d    = br_c;
    fl_d    = fl_c;
    v3_d    = v3_q;
    v4_d    = v4_q;
    ext_d   = ext_q;
    tgt_d   = tgt_q;
    enc0_d  = enc0_q;
    enc1_d  = enc1_q;
    odd_d   = odd_q;
    first_d = first_q;
    bom_d   = bom_q;

    fh_new   = {fh_c[23:0], data_byte_i};
    t32      = {br_c[24:0], data_byte_i[6:0]};
    rem      = br_c - 32'd1;
    limit    = tgt_q ? artist_max_q : title_max_q;
    ft       = 1'b0;
    kept     = 1'b1;
    start_fh = 1'b0;
    fin_tag  = 1'b0;
    no_tag   = 1'b0;
    stop     = 1'b0;
    char_v   = 1'b0;
    char_val = data_byte_i;
    fl_dec   = '0;

    if (acc_i) begin
      unique case (phase_c)
        PH_HDR: begin
          if (bc_c == 4'd0 && data_byte_i != MAGIC_0) mok_d = 1'b0;
          if (bc_c == 4'd1 && data_byte_i != MAGIC_1) mok_d = 1'b0;
          if (bc_c == 4'd2 && data_byte_i != MAGIC_2) mok_d = 1'b0;
          if (bc_c == 4'd3) begin
            v3_d = (data_byte_i == VER_3);
            v4_d = (data_byte_i == VER_4);
          end
          if (bc_c == 4'd5) ext_d = data_byte_i[EXT_FLAG_BIT];
          if (bc_c >= 4'd6) ts_d = {ts_c[TAG_SIZE_W-8:0], data_byte_i[6:0]};
          if (bc_c < 4'd9) begin
            bc_d = bc_c + 4'd1;
          end else begin
            bc_d = '0;
            if (!mok_c) begin
              no_tag  = 1'b1;
              phase_d = PH_DONE;
            end else if (ext_q) begin
              phase_d = PH_EXT_SIZE;
              br_d    = '0;
            end else begin
              start_fh = 1'b1;
            end
          end
        end
        PH_EXT_SIZE: begin
          if (bc_c < 4'd3) begin
            bc_d = bc_c + 4'd1;
            br_d = t32;
          end else begin
            bc_d = '0;
            if (t32 <= 32'd4) begin
              start_fh = 1'b1;
            end else begin
              br_d    = t32 - 32'd4;
              phase_d = PH_EXT_SKIP;
            end
          end
        end
        PH_EXT_SKIP, PH_FR_SKIP: begin
          br_d = rem;
          if (rem == '0) start_fh = 1'b1;
        end
        PH_FR_HDR: begin
          if (bc_c < 4'd4) begin
            if (bc_c == 4'd0 && data_byte_i == '0) begin
              fin_tag = 1'b1;
              stop    = 1'b1;
            end else begin
              fh_d = fh_new;
              if (bc_c == 4'd2 && fh_new[23:0] == ID_FOOT) begin
                fin_tag = 1'b1;
                stop    = 1'b1;
              end
            end
          end else if (bc_c < 4'd8) begin
            if (v3_q) br_d = {br_c[23:0], data_byte_i};
            else if (v4_q) br_d = t32;
          end
          if (!stop) begin
            if (bc_c < 4'd9) begin
              bc_d = bc_c + 4'd1;
            end else begin
              bc_d = '0;
              if (fh_c == ID_TPE1 || fh_c == ID_TIT2) begin
                tgt_d = (fh_c == ID_TPE1);
                if (br_c == '0) ft = 1'b1;
                else phase_d = PH_TX_ENC;
              end else if (br_c == '0) begin
                start_fh = 1'b1;
              end else begin
                phase_d = PH_FR_SKIP;
              end
            end
          end
        end
        PH_TX_ENC: begin
          enc0_d = (data_byte_i == ENC_LATIN);
          enc1_d = (data_byte_i == ENC_UTF16);
          br_d   = rem;
          if (rem > {25'd0, limit}) phase_d = PH_TX_SKIP;
          else if (rem == '0) ft = 1'b1;
          else if (data_byte_i == ENC_UTF16) phase_d = PH_TX_FIRST;
          else phase_d = PH_TX_REST;
        end
        PH_TX_FIRST: begin
          first_d = data_byte_i;
          br_d    = rem;
          if (rem == '0) begin
            char_v = 1'b1;
            ft     = 1'b1;
          end else begin
            bom_d   = (rem >= 32'd2);
            phase_d = PH_TX_SEC;
          end
        end
        PH_TX_SEC: begin
          br_d     = rem;
          char_val = first_q;
          char_v   = !(bom_q && first_q == BOM_FIRST && data_byte_i == BOM_SECOND);
          odd_d    = 1'b0;
          if (rem == '0) ft = 1'b1;
          else phase_d = PH_TX_REST;
        end
        PH_TX_REST: begin
          if (enc0_q) begin
            char_v = 1'b1;
          end else if (enc1_q) begin
            char_v = !odd_q;
            odd_d  = !odd_q;
          end
          br_d = rem;
          if (rem == '0) ft = 1'b1;
        end
        PH_TX_SKIP: begin
          br_d = rem;
          kept = 1'b0;
          if (rem == '0) ft = 1'b1;
        end
        default: ;
      endcase
    end

    // end of a text frame
    if (ft) begin
      fl_dec = (fl_c != '0) ? fl_c - 2'd1 : '0;
      fl_d   = fl_dec;
      if (fl_dec == '0) fin_tag = 1'b1;
      else start_fh = 1'b1;
    end
    if (start_fh) begin
      phase_d = PH_FR_HDR;
      bc_d    = '0;
      fh_d    = '0;
      br_d    = '0;
    end
    if (fin_tag) phase_d = PH_DONE;

    // pack results in order: character, end marker, tag done or no tag
    res_o = '0;
    cnt   = '0;
    if (char_v) begin
      res_o.res[cnt].kind      = tgt_d ? KIND_ARTIST_CHAR : KIND_TITLE_CHAR;
      res_o.res[cnt].char_code = char_val;
      cnt = cnt + 2'd1;
    end
    if (ft && kept) begin
      res_o.res[cnt].kind = tgt_d ? KIND_ARTIST_END : KIND_TITLE_END;
      cnt = cnt + 2'd1;
    end
    if (fin_tag) begin
      res_o.res[cnt].kind    = KIND_TAG_DONE;
      res_o.res[cnt].tag_end = {1'b0, ts_c} + HDR_LEN;
      cnt = cnt + 2'd1;
    end
    if (no_tag) begin
      res_o.res[cnt].kind = KIND_NO_TAG;
      cnt = cnt + 2'd1;
    end
    if (cnt != '0) res_o.res[cnt - 2'd1].last = 1'b1;
    res_o.count = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      ts_q    <= '0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ext_q   <= 1'b0;
      mok_q   <= 1'b0;
      fh_q    <= '0;
      br_q    <= '0;
      fl_q    <= TEXT_FRAMES;
      tgt_q   <= 1'b0;
      enc0_q  <= 1'b1;
      enc1_q  <= 1'b0;
      odd_q   <= 1'b0;
      first_q <= '0;
      bom_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      ts_q    <= ts_d;
      v3_q    <= v3_d;
      v4_q    <= v4_d;
      ext_q   <= ext_d;
      mok_q   <= mok_d;
      fh_q    <= fh_d;
      br_q    <= br_d;
      fl_q    <= fl_d;
      tgt_q   <= tgt_d;
      enc0_q  <= enc0_d;
      enc1_q  <= enc1_d;
      odd_q   <= odd_d;
      first_q <= first_d;
      bom_q   <= bom_d;
    end
  end

endmodule

`default_nettype wire

### rtl/i3p_res_buf.sv
`default_nettype none

module i3p_res_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire i3p_pkg::result_set_t push_i,
  input  wire logic                 pop_i,
  output i3p_pkg::result_t          head_o,
  output logic                      valid_o,
  output logic                      room_o
);
  import i3p_pkg::*;

  result_t                slot_q [BUF_DEPTH];
  result_t                slot_d [BUF_DEPTH];
  logic [BUF_CNT_W-1:0]   cnt_q, cnt_d;
  logic [BUF_CNT_W-1:0]   base;

  assign base  = cnt_q - BUF_CNT_W'(pop_i);
  assign cnt_d = base + BUF_CNT_W'(push_i.count);

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (pop_i && i < BUF_DEPTH - 1) slot_d[i] = slot_q[(i + 1) % BUF_DEPTH];
      else slot_d[i] = slot_q[i];
      for (int k = 0; k < MAX_RES; k++) begin
        if (RES_CNT_W'(k) < push_i.count && base + BUF_CNT_W'(k) == BUF_CNT_W'(i)) begin
          slot_d[i] = push_i.res[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BUF_DEPTH; i++) slot_q[i] <= slot_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // room for a full set of results from one byte
  assign room_o  = (cnt_q <= BUF_CNT_W'(BUF_DEPTH - MAX_RES));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[0];

endmodule

`default_nettype wire

### rtl/id3v2_text_tag_parser.sv
`default_nettype none

// ID3v2 text tag parser. File bytes enter one per transfer on in_i, with
// start_of_file set on byte 0 of each file; the block checks the tag header,
// walks the frames and returns artist and title characters, their end markers
// and a final tag done (with the audio start offset) or no tag result on out_o,
// one result per transfer. A byte is decided in the cycle it is taken; its
// results queue in the four-entry buffer feeding out_o. Throughput is one byte
// per cycle while each byte gives at most one result and out_o takes each;
// in_i.ready drops while two or more results wait. Artist and title length
// limits are written on cfg_i (index 0 artist, 1 title, reset 127) by the user
// only while idle; the block does not enforce this.
module id3v2_text_tag_parser (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  i3p_cfg_if.sink       cfg_i,
  i3p_byte_if.sink      in_i,
  i3p_result_if.source  out_o
);
  import i3p_pkg::*;

  logic        in_acc;
  logic        pop;
  logic        room;
  logic        head_valid;
  result_set_t res_set;
  result_t     head;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = room;
  assign in_acc      = in_i.valid && room;
  assign pop         = head_valid && out_o.ready;

  i3p_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .acc_i       (in_acc),
    .data_byte_i (in_i.data_byte),
    .sof_i       (in_i.start_of_file),
    .res_o       (res_set)
  );

  i3p_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_set),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_o.valid     = head_valid;
  assign out_o.kind      = head.kind;
  assign out_o.char_code = head.char_code;
  assign out_o.tag_end   = head.tag_end;
  assign out_o.last      = head.last;

endmodule

`default_nettype wire

### rtl/i3p_checker.sv
`default_nettype none

module i3p_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  kind_i,
  input wire logic [7:0]  char_code_i,
  input wire logic [28:0] tag_end_i,
  input wire logic        last_i
);
  import i3p_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(char_code_i)
      && $stable(tag_end_i) && $stable(last_i))
    else $error("result changed while stalled");

  // input only backs up behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // no result appears without a byte transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result appeared without a byte");

  // no tag result is final and empty
  a_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_NO_TAG |-> last_i && tag_end_i == '0 && char_code_i == '0)
    else $error("malformed no tag result");

endmodule

bind id3v2_text_tag_parser i3p_checker u_i3p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .char_code_i (out_o.char_code),
  .tag_end_i   (out_o.tag_end),
  .last_i      (out_o.last)
);

`default_nettype wire

### test/tb_top.sv
`default_nettype none

import i3p_pkg::*;

typedef enum logic [1:0] {
  TGT_NONE,
  TGT_ARTIST,
  TGT_TITLE
} text_target_e;

class tag_scoreboard;
  result_t      expected_q[$];
  result_t      batch[$];
  int           errors;
  logic [6:0]   artist_lim;
  logic [6:0]   title_lim;
  phase_e       ph;
  logic [3:0]   cnt;
  logic [27:0]  tsize;
  logic [7:0]   ver;
  logic [7:0]   flags;
  logic [7:0]   enc;
  logic [7:0]   first_b;
  logic [31:0]  fid;
  logic [31:0]  remain;
  logic [1:0]   frames_left;
  text_target_e target;
  bit           odd;
  bit           magic_ok;
  bit           bom_ok;

  function new();
    errors     = 0;
    artist_lim = LEN_RESET;
    title_lim  = LEN_RESET;
    clear();
  endfunction

  function void clear();
    ph          = PH_IDLE;
    cnt         = '0;
    tsize       = '0;
    ver         = '0;
    flags       = '0;
    enc         = '0;
    first_b     = '0;
    fid         = '0;
    remain      = '0;
    frames_left = TEXT_FRAMES;
    target      = TGT_NONE;
    odd         = 1'b0;
    magic_ok    = 1'b0;
    bom_ok      = 1'b0;
  endfunction

  function void set_limit(cfg_idx_e idx, logic [6:0] val);
    if (idx == CFG_ARTIST_MAX) artist_lim = val;
    else if (idx == CFG_TITLE_MAX) title_lim = val;
  endfunction

  function void push(kind_e k, logic [7:0] ch, logic [TAG_END_W-1:0] te);
    result_t r;
    r.kind      = k;
    r.char_code = ch;
    r.tag_end   = te;
    r.last      = 1'b0;
    batch.push_back(r);
  endfunction

  function void push_char(logic [7:0] ch);
    push(target == TGT_ARTIST ? KIND_ARTIST_CHAR : KIND_TITLE_CHAR, ch, '0);
  endfunction

  function void close_tag();
    push(KIND_TAG_DONE, '0, {1'b0, tsize} + HDR_LEN);
    ph = PH_DONE;
  endfunction

  function void next_frame();
    ph     = PH_FR_HDR;
    cnt    = '0;
    fid    = '0;
    remain = '0;
  endfunction

  function void end_text(bit kept);
    if (kept) push(target == TGT_ARTIST ? KIND_ARTIST_END : KIND_TITLE_END, '0, '0);
    if (frames_left != 0) frames_left--;
    target = TGT_NONE;
    if (frames_left == 0) close_tag();
    else next_frame();
  endfunction

  // works out the results of one accepted byte and queues them
  function void note_byte(logic [7:0] b, bit sof);
    logic [7:0] magic_b;
    logic [6:0] lim;
    batch.delete();
    if (sof) begin
      clear();
      ph       = PH_HDR;
      magic_ok = 1'b1;
    end
    case (ph)
      PH_HDR: begin
        if (cnt < 3) begin
          magic_b = (cnt == 0) ? MAGIC_0 : (cnt == 1) ? MAGIC_1 : MAGIC_2;
          if (b != magic_b) magic_ok = 1'b0;
        end else if (cnt == 3) begin
          ver = b;
        end else if (cnt == 5) begin
          flags = b;
        end else if (cnt >= 6) begin
          tsize = {tsize[20:0], b[6:0]};
        end
        if (cnt < 9) begin
          cnt++;
        end else begin
          cnt = '0;
          if (!magic_ok) begin
            push(KIND_NO_TAG, '0, '0);
            ph = PH_DONE;
          end else if (flags[EXT_FLAG_BIT]) begin
            ph     = PH_EXT_SIZE;
            remain = '0;
          end else begin
            next_frame();
          end
        end
      end
      PH_EXT_SIZE: begin
        remain = {remain[24:0], b[6:0]};
        if (cnt < 3) begin
          cnt++;
        end else begin
          cnt    = '0;
          remain = (remain >= 4) ? remain - 4 : '0;
          if (remain == 0) next_frame();
          else ph = PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP, PH_FR_SKIP: begin
        remain--;
        if (remain == 0) next_frame();
      end
      PH_FR_HDR: begin
        if (cnt == 0 && b == 8'h00) begin
          close_tag();
        end else begin
          if (cnt < 4) fid = {fid[23:0], b};
          else if (cnt < 8) begin
            if (ver == VER_3) remain = {remain[23:0], b};
            else if (ver == VER_4) remain = {remain[24:0], b[6:0]};
          end
          if (cnt == 2 && fid[23:0] == ID_FOOT) begin
            close_tag();
          end else if (cnt < 9) begin
            cnt++;
          end else begin
            cnt = '0;
            if (fid == ID_TPE1 || fid == ID_TIT2) begin
              target = (fid == ID_TPE1) ? TGT_ARTIST : TGT_TITLE;
              if (remain == 0) end_text(1'b1);
              else ph = PH_TX_ENC;
            end else if (remain == 0) begin
              next_frame();
            end else begin
              ph = PH_FR_SKIP;
            end
          end
        end
      end
      PH_TX_ENC: begin
        enc = b;
        remain--;
        lim = (target == TGT_ARTIST) ? artist_lim : title_lim;
        if (remain > lim) ph = PH_TX_SKIP;
        else if (remain == 0) end_text(1'b1);
        else if (enc == ENC_UTF16) ph = PH_TX_FIRST;
        else ph = PH_TX_REST;
      end
      PH_TX_FIRST: begin
        first_b = b;
        remain--;
        if (remain == 0) begin
          push_char(b);
          end_text(1'b1);
        end else begin
          bom_ok = (remain >= 2);
          ph     = PH_TX_SEC;
        end
      end
      PH_TX_SEC: begin
        remain--;
        if (!(bom_ok && first_b == BOM_FIRST && b == BOM_SECOND)) push_char(first_b);
        odd = 1'b0;
        if (remain == 0) end_text(1'b1);
        else ph = PH_TX_REST;
      end
      PH_TX_REST: begin
        if (enc == ENC_LATIN) begin
          push_char(b);
        end else if (enc == ENC_UTF16) begin
          if (!odd) push_char(b);
          odd = ~odd;
        end
        remain--;
        if (remain == 0) end_text(1'b1);
      end
      PH_TX_SKIP: begin
        remain--;
        if (remain == 0) end_text(1'b0);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endfunction

  function void check_result(logic [2:0] kind, logic [7:0] ch, logic [TAG_END_W-1:0] te,
                             logic last);
    result_t want;
    if (expected_q.size() == 0) begin
      if (errors < 40) $error("unexpected result: kind %0d char %0h", kind, ch);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (kind !== want.kind) begin
      if (errors < 40) $error("kind: expected %0d, got %0d", want.kind, kind);
      errors++;
    end
    if (ch !== want.char_code) begin
      if (errors < 40) $error("char_code: expected %0h, got %0h", want.char_code, ch);
      errors++;
    end
    if (te !== want.tag_end) begin
      if (errors < 40) $error("tag_end: expected %0d, got %0d", want.tag_end, te);
      errors++;
    end
    if (last !== want.last) begin
      if (errors < 40) $error("last: expected %0d, got %0d", want.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;

  i3p_cfg_if    cfg_if ();
  i3p_byte_if   in_if ();
  i3p_result_if res_if ();

  id3v2_text_tag_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (res_if)
  );

  tag_scoreboard sb;
  logic [7:0]    file_bytes[$];
  int            src_idle_pct;
  int            snk_stall_pct;
  int            stall_cycles;

  always #5 clk_i = ~clk_i;

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.kind, res_if.char_code, res_if.tag_end, res_if.last);
    res_if.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit sof);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.start_of_file <= sof;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(b, sof);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_limits(logic [6:0] artist, logic [6:0] title);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ARTIST_MAX;
    cfg_if.data  <= artist;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_limit(CFG_ARTIST_MAX, artist);
    cfg_if.index <= CFG_TITLE_MAX;
    cfg_if.data  <= title;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_limit(CFG_TITLE_MAX, title);
    cfg_if.valid <= 1'b0;
  endtask

  // one random file: mostly well-formed tags with small frames, some noise
  function automatic void build_file();
    int unsigned sel;
    int unsigned pick;
    int unsigned len;
    int unsigned body;
    int unsigned ext_len;
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [7:0]  m2;
    logic [7:0]  ver;
    logic [7:0]  enc;
    logic [31:0] fid;
    bit          ext;
    bit          is_text;
    file_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 14)) file_bytes.push_back(8'($urandom));
      return;
    end
    m0 = MAGIC_0;
    m1 = MAGIC_1;
    m2 = MAGIC_2;
    if (sel < 16) begin
      case ($urandom_range(2))
        0: m0 ^= 8'($urandom_range(1, 255));
        1: m1 ^= 8'($urandom_range(1, 255));
        default: m2 ^= 8'($urandom_range(1, 255));
      endcase
    end
    pick = $urandom_range(99);
    ver  = (pick < 45) ? VER_3 : (pick < 90) ? VER_4 : 8'($urandom);
    ext  = ($urandom_range(3) == 0);
    file_bytes.push_back(m0);
    file_bytes.push_back(m1);
    file_bytes.push_back(m2);
    file_bytes.push_back(ver);
    file_bytes.push_back(8'($urandom));
    file_bytes.push_back((8'($urandom) & 8'hBF) | (ext ? 8'h40 : 8'h00));
    repeat (4) file_bytes.push_back(8'($urandom));
    if (ext) begin
      ext_len = $urandom_range(0, 9);
      repeat (3) file_bytes.push_back(8'($urandom) & 8'h80);
      file_bytes.push_back(8'(ext_len) | (8'($urandom) & 8'h80));
      if (ext_len > 4) repeat (ext_len - 4) file_bytes.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 2)) begin
      pick    = $urandom_range(99);
      is_text = (pick < 80);
      if (pick < 40) fid = ID_TPE1;
      else if (pick < 80) fid = ID_TIT2;
      else fid = {8'($urandom_range(65, 90)), 8'($urandom), 8'($urandom), 8'($urandom)};
      len = ($urandom_range(15) == 0) ? $urandom_range(8, 140) : $urandom_range(0, 7);
      if (ver != VER_3 && ver != VER_4) len = 0;
      file_bytes.push_back(fid[31:24]);
      file_bytes.push_back(fid[23:16]);
      file_bytes.push_back(fid[15:8]);
      file_bytes.push_back(fid[7:0]);
      if (ver == VER_3) begin
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'(len >> 8));
        file_bytes.push_back(8'(len));
      end else if (ver == VER_4) begin
        file_bytes.push_back(8'($urandom) & 8'h80);
        file_bytes.push_back(8'($urandom) & 8'h80);
        file_bytes.push_back(8'(len >> 7) | (8'($urandom) & 8'h80));
        file_bytes.push_back(8'(len & 7'h7F) | (8'($urandom) & 8'h80));
      end else begin
        repeat (4) file_bytes.push_back(8'($urandom));
      end
      repeat (2) file_bytes.push_back(8'($urandom));
      if (len > 0 && is_text) begin
        pick = $urandom_range(99);
        enc  = (pick < 40) ? ENC_LATIN : (pick < 85) ? ENC_UTF16 : 8'($urandom);
        file_bytes.push_back(enc);
        body = len - 1;
        if (enc == ENC_UTF16 && len >= 4 && $urandom_range(1) == 1) begin
          file_bytes.push_back(BOM_FIRST);
          file_bytes.push_back(BOM_SECOND);
          body -= 2;
        end
        repeat (body) file_bytes.push_back(8'($urandom));
      end else begin
        repeat (len) file_bytes.push_back(8'($urandom));
      end
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      file_bytes.push_back(8'h00);
    end else if (pick < 55) begin
      file_bytes.push_back(ID_FOOT[23:16]);
      file_bytes.push_back(ID_FOOT[15:8]);
      file_bytes.push_back(ID_FOOT[7:0]);
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
  endfunction

  initial begin
    int sent;
    int nfiles;
    sb                   = new();
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    stall_cycles         = 0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.start_of_file  = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_ARTIST_MAX;
    cfg_if.data          = '0;
    res_if.ready         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          write_limits(LEN_RESET, LEN_RESET);
        end
        1: begin
          src_idle_pct  = 71;
          snk_stall_pct = 0;
          write_limits(7'd0, LEN_RESET);
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 71;
          write_limits(7'd5, 7'd0);
        end
        default: begin
          src_idle_pct  = 6;
          snk_stall_pct = 6;
          write_limits(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        end
      endcase

      if (stage == 0) begin
        // bytes before any file are ignored
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // broken magic, then a byte after the verdict
        file_bytes = '{MAGIC_0, MAGIC_1, 8'h34, VER_3, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h00, 8'h00};
        send_file();
        send_byte(MAGIC_0, 1'b0);
        // largest tag size, short extended header, empty artist, utf-16 title with bom
        file_bytes = '{MAGIC_0, MAGIC_1, MAGIC_2, VER_4, 8'h00, 8'h40,
                       8'h7F, 8'h7F, 8'h7F, 8'h7F,
                       8'h80, 8'h80, 8'h80, 8'h82,
                       8'h54, 8'h50, 8'h45, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h05, 8'hFF, 8'hFF,
                       ENC_UTF16, BOM_FIRST, BOM_SECOND, 8'h41, 8'h00};
        send_file();
      end

      sent   = 0;
      nfiles = 0;
      while (sent < 12) begin
        build_file();
        send_file();
        sent += file_bytes.size();
        nfiles++;
        if (nfiles == 1) drain();
      end
      drain();
      repeat (8) @(posedge clk_i);
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
